[src/ltf_pkg.sv]
// Shared types and constants for the LED twinkle/fade engine.
// No dependencies; imported by every module of the block.
package ltf_pkg;

	localparam int MAX_PIXELS = 64;
	localparam int PIX_IDX_W  = $clog2(MAX_PIXELS);
	localparam int PIX_CNT_W  = PIX_IDX_W + 1;
	localparam int LEVEL_W    = 8;

	// Configuration register indexes
	localparam logic [1:0] CFG_FADE_RATE   = 2'd0;
	localparam logic [1:0] CFG_STAR_PERIOD = 2'd1;
	localparam logic [1:0] CFG_PIXEL_COUNT = 2'd2;

	localparam logic [LEVEL_W-1:0]   FADE_RATE_RST   = 8'd20;
	localparam logic [LEVEL_W-1:0]   STAR_PERIOD_RST = 8'd3;
	localparam logic [PIX_CNT_W-1:0] PIXEL_COUNT_RST = PIX_CNT_W'(MAX_PIXELS);

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} pixel_t;

	// Control handed from the sequencer to the fade unit for the head pixel
	typedef struct packed {
		logic               in_range;
		logic               star_hit;
		logic [LEVEL_W-1:0] rate;
	} fade_ctl_t;

endpackage

[src/led_twinkle_fade_engine.sv]
// An accepted frame tick starts a run; each in-range ring step then loads the output register.
// A new frame tick is taken only while idle. The pixel ring of MAX_PIXELS cells
// rotates once per tick, one pixel per cycle, and stalls while a result waits.
// Reset (arst_n low, asynchronous): all pixels dark, frame counter zero,
// registers at fade_rate 20, star_period 3, pixel_count 64; no clearing pass.
module led_twinkle_fade_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [7:0]                          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ltf_pkg::PIX_IDX_W-1:0]       star_pixel,
	input  logic [ltf_pkg::LEVEL_W-1:0]         star_red,
	input  logic [ltf_pkg::LEVEL_W-1:0]         star_green,
	input  logic [ltf_pkg::LEVEL_W-1:0]         star_blue,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ltf_pkg::PIX_IDX_W-1:0]       pixel_index,
	output logic [ltf_pkg::LEVEL_W-1:0]         red,
	output logic [ltf_pkg::LEVEL_W-1:0]         green,
	output logic [ltf_pkg::LEVEL_W-1:0]         blue,
	output logic                                last_pixel
);
	import ltf_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                 state_q;
	logic [LEVEL_W-1:0]   fade_rate_q;
	logic [LEVEL_W-1:0]   star_period_q;
	logic [PIX_CNT_W-1:0] pixel_count_q;
	logic [LEVEL_W-1:0]   frame_count_q;
	logic [PIX_CNT_W-1:0] active_q;
	logic [PIX_IDX_W-1:0] idx_q;
	logic                 star_due_q;
	logic [PIX_IDX_W-1:0] star_px_q;
	pixel_t               star_q;

	logic                 out_valid_q;
	logic [PIX_IDX_W-1:0] out_idx_q;
	pixel_t               out_pix_q;
	logic                 out_last_q;

	logic                 in_acc;
	logic                 advance;
	logic                 in_range;
	logic                 last_step;
	logic [LEVEL_W-1:0]   fc_inc;
	fade_ctl_t            ctl;
	pixel_t               faded;
	pixel_t               ring_q [MAX_PIXELS];
	pixel_t               ring_d [MAX_PIXELS];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign advance   = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign in_range  = {1'b0, idx_q} < active_q;
	assign last_step = idx_q == PIX_IDX_W'(MAX_PIXELS - 1);
	assign fc_inc    = frame_count_q + 8'd1;

	assign ctl.in_range = in_range;
	assign ctl.star_hit = star_due_q && (star_px_q == idx_q);
	assign ctl.rate     = fade_rate_q;

	ltf_fade_unit u_fade (
		.head  (ring_q[0]),
		.star  (star_q),
		.ctl   (ctl),
		.faded (faded)
	);

	// ring: cell k takes cell k+1, the last cell takes the updated head pixel
	genvar k;
	generate
		for (k = 0; k < MAX_PIXELS; k++) begin : g_cell
			if (k == MAX_PIXELS - 1) begin : g_tail
				assign ring_d[k] = faded;
			end else begin : g_body
				assign ring_d[k] = ring_q[k+1];
			end
			ltf_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (advance),
				.d      (ring_d[k]),
				.q      (ring_q[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_rate_q   <= FADE_RATE_RST;
			star_period_q <= STAR_PERIOD_RST;
			pixel_count_q <= PIXEL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FADE_RATE:   fade_rate_q   <= cfg_data;
				CFG_STAR_PERIOD: star_period_q <= cfg_data;
				CFG_PIXEL_COUNT: pixel_count_q <= cfg_data[PIX_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_count_q <= '0;
			idx_q         <= '0;
			star_due_q    <= 1'b0;
			active_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						// wrap the frame counter and flag a star when the period is reached
						if (fc_inc >= star_period_q) begin
							frame_count_q <= '0;
							star_due_q    <= 1'b1;
						end else begin
							frame_count_q <= fc_inc;
							star_due_q    <= 1'b0;
						end
						active_q <= (pixel_count_q > PIX_CNT_W'(MAX_PIXELS)) ?
						            PIX_CNT_W'(MAX_PIXELS) : pixel_count_q;
					end
				end
				ST_RUN: begin
					if (advance) begin
						idx_q <= idx_q + 1'b1;
						if (last_step) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			star_px_q <= star_pixel;
			star_q    <= '{red: star_red, green: star_green, blue: star_blue};
		end
	end

	// output register: load on an in-range step, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && in_range) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_range) begin
			out_idx_q  <= idx_q;
			out_pix_q  <= faded;
			out_last_q <= ({1'b0, idx_q} + PIX_CNT_W'(1)) == active_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = out_idx_q;
	assign red         = out_pix_q.red;
	assign green       = out_pix_q.green;
	assign blue        = out_pix_q.blue;
	assign last_pixel  = out_last_q;

`ifndef ASSERT_OFF
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN) && (idx_q == '0))
		else $error("frame did not start at pixel zero");

	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_step) |=> (state_q == ST_IDLE))
		else $error("ring walk did not end after the last cell");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("pixel counter not home while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("ring advanced over a pending result");
`endif

endmodule

[src/ltf_cell.sv]
// One storage cell of the pixel ring: holds one pixel colour.
// Depends on ltf_pkg for pixel_t.
module ltf_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  ltf_pkg::pixel_t d,
	output ltf_pkg::pixel_t q
);
	import ltf_pkg::*;

	pixel_t pix_q;

	// take the neighbor's colour on every ring step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift) begin
			pix_q <= d;
		end
	end

	assign q = pix_q;

endmodule

[src/ltf_fade_unit.sv]
// Per-step pixel update: star insertion followed by saturating fade for in-range pixels.
// Depends on ltf_pkg for pixel_t and fade_ctl_t.
module ltf_fade_unit (
	input  ltf_pkg::pixel_t    head,
	input  ltf_pkg::pixel_t    star,
	input  ltf_pkg::fade_ctl_t ctl,
	output ltf_pkg::pixel_t    faded
);
	import ltf_pkg::*;

	pixel_t src;

	function automatic logic [LEVEL_W-1:0] fade_ch(input logic [LEVEL_W-1:0] lvl,
	                                               input logic [LEVEL_W-1:0] rate);
		fade_ch = (lvl > rate) ? (lvl - rate) : '0;
	endfunction

	always_comb begin
		src = ctl.star_hit ? star : head;
		if (ctl.in_range) begin
			faded.red   = fade_ch(src.red,   ctl.rate);
			faded.green = fade_ch(src.green, ctl.rate);
			faded.blue  = fade_ch(src.blue,  ctl.rate);
		end else begin
			// inactive pixels pass around the ring untouched
			faded = head;
		end
	end

endmodule
